### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the MFM track decoder.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while reset is asserted (active-low reset).
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed under reset qualifier");

// Checked property, evaluated at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

### rtl/mtd_pkg.sv
// Constants and result codes for the MFM track decoder.
// No dependencies; imported by mtd_out_if and the top level.
`default_nettype none

package mtd_pkg;

    localparam int MaxWords = 2048;
    localparam int WcW      = $clog2(MaxWords);
    localparam int TwW      = 12;
    localparam int WordW    = 32;
    localparam int BitCntW  = 6;
    localparam int IdxW     = 11;

    localparam logic [WordW-1:0] SyncWord = 32'haaaa4425;
    localparam logic [WordW-1:0] MfmMask  = 32'h55555555;
    localparam logic [WordW-1:0] SumBias  = 32'd4;

    localparam logic [TwW-1:0]   TrackWordsRst  = 12'd1562;
    localparam logic [WordW-1:0] ExpectedSumRst = 32'hab5de67a;

    // r_bit value on the transfer that completes the odd or even half
    localparam logic [BitCntW-1:0] OddDone  = 6'd31;
    localparam logic [BitCntW-1:0] EvenDone = 6'd63;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_END  = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_TRACK_WORDS  = 1'b0,
        CFG_EXPECTED_SUM = 1'b1
    } t_cfg_index;

endpackage

`default_nettype wire

### rtl/mtd_in_if.sv
// Raw bit stream channel: valid/ready plus one raw MFM bit and an end flag.
// No dependencies.
`default_nettype none

interface mtd_in_if;
    logic valid;
    logic ready;
    logic raw_bit;
    logic stream_end;

    modport source (output valid, output raw_bit, output stream_end, input ready);
    modport sink   (input valid, input raw_bit, input stream_end, output ready);
endinterface

`default_nettype wire

### rtl/mtd_out_if.sv
// Decoded word channel: valid/ready plus kind, data word and word index.
// Depends on mtd_pkg for the result code type and field widths.
`default_nettype none

interface mtd_out_if import mtd_pkg::*; ();
    logic              valid;
    logic              ready;
    t_kind             kind;
    logic [WordW-1:0]  data_word;
    logic [IdxW-1:0]   word_index;

    modport source (output valid, output kind, output data_word, output word_index,
                    input ready);
    modport sink   (input valid, input kind, input data_word, input word_index,
                    output ready);
endinterface

`default_nettype wire

### rtl/mfm_track_decoder_with_sum_check.sv
// MFM track decoder: sync search, odd/even word decode, folded-carry sum check.
// Depends on mtd_pkg, mtd_in_if, mtd_out_if and assert_macros.svh.
//
//   port      dir  width  carries
//   i_bits    in   1+1    raw_bit, stream_end
//   o_words   out  2+32+11 kind, data_word, word_index
//   i_cfg_*   in   1+32   register index and write data
//
// One raw bit is taken every cycle while i_bits.ready is high; its result (if any)
// is registered into the output register, or, while that one is held, into a skid
// register behind it that holds one more; i_bits.ready drops only when both are full.
// All per-bit work (shift, sync compare, one folded 32-bit add) is combinational.
// Reset is synchronous, active low; config registers return to their defaults.
`default_nettype none

`include "assert_macros.svh"

module mfm_track_decoder_with_sum_check import mtd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [WordW-1:0]  i_cfg_data,
    mtd_in_if.sink                 i_bits,
    mtd_out_if.source              o_words
);

    function automatic logic [WordW-1:0] fold_add(input logic [WordW-1:0] a,
                                                  input logic [WordW-1:0] b);
        logic [WordW:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[WordW-1:0] + {{(WordW-1){1'b0}}, t[WordW]};
    endfunction

    // configuration
    logic [TwW-1:0]   r_track_words;
    logic [WordW-1:0] r_expected_sum;
    logic [WcW-1:0]   len_m1;

    // decoder state
    logic [WordW-1:0]   r_win,  n_win;
    logic               r_coll, n_coll;
    logic [BitCntW-1:0] r_bit,  n_bit;
    logic [WcW-1:0]     r_wc,   n_wc;
    logic [WordW-1:0]   r_odd,  n_odd;
    logic [WordW-1:0]   r_sum,  n_sum;

    // output and skid registers
    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [WordW-1:0]  r_out_data;
    logic [IdxW-1:0]   r_out_idx;
    logic              r_skid_valid;
    t_kind             r_skid_kind;
    logic [WordW-1:0]  r_skid_data;
    logic [IdxW-1:0]   r_skid_idx;

    logic              in_xfer;
    logic              out_xfer;
    logic [WordW-1:0]  shifted;
    logic [WordW-1:0]  decoded;
    logic              last_word;
    logic              res_valid;
    t_kind             res_kind;
    logic [WordW-1:0]  res_data;
    logic [IdxW-1:0]   res_idx;

    assign i_bits.ready       = !r_skid_valid;
    assign in_xfer            = i_bits.valid && !r_skid_valid;
    assign out_xfer           = r_out_valid && o_words.ready;
    assign o_words.valid      = r_out_valid;
    assign o_words.kind       = r_out_kind;
    assign o_words.data_word  = r_out_data;
    assign o_words.word_index = r_out_idx;

    // effective track length minus one, clamped to 1..MaxWords
    always_comb begin
        if (r_track_words == '0) begin
            len_m1 = '0;
        end else if (r_track_words > TwW'(MaxWords)) begin
            len_m1 = WcW'(MaxWords - 1);
        end else begin
            len_m1 = WcW'(r_track_words - TwW'(1));
        end
    end

    assign shifted   = {r_win[WordW-2:0], i_bits.raw_bit};
    assign decoded   = ((r_odd & MfmMask) << 1) | (shifted & MfmMask);
    assign last_word = (r_wc >= len_m1);

    always_comb begin
        n_win     = r_win;
        n_coll    = r_coll;
        n_bit     = r_bit;
        n_wc      = r_wc;
        n_odd     = r_odd;
        n_sum     = r_sum;
        res_valid = 1'b0;
        res_kind  = KIND_DATA;
        res_data  = decoded;
        res_idx   = IdxW'(r_wc);
        if (in_xfer) begin
            if (i_bits.stream_end) begin
                res_valid = 1'b1;
                res_kind  = KIND_END;
                res_data  = '0;
                n_win     = '0;
                n_coll    = 1'b0;
                n_bit     = '0;
                n_wc      = '0;
                n_odd     = '0;
                n_sum     = '0;
            end else begin
                n_win = shifted;
                if (!r_coll) begin
                    // run state is already clear while searching
                    if (shifted == SyncWord) begin
                        n_coll = 1'b1;
                    end
                end else begin
                    n_bit = r_bit + BitCntW'(1);
                    if (r_bit == OddDone) begin
                        n_odd = shifted;
                        n_sum = fold_add(r_sum, shifted);
                    end else if (r_bit == EvenDone) begin
                        res_valid = 1'b1;
                        if (!last_word) begin
                            res_kind = KIND_DATA;
                            n_sum    = fold_add(r_sum, shifted);
                            n_wc     = r_wc + WcW'(1);
                        end else begin
                            res_kind = ((r_sum + SumBias) == r_expected_sum) ?
                                       KIND_GOOD : KIND_BAD;
                            n_coll   = 1'b0;
                            n_bit    = '0;
                            n_wc     = '0;
                            n_odd    = '0;
                            n_sum    = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_words  <= TrackWordsRst;
            r_expected_sum <= ExpectedSumRst;
            r_win          <= '0;
            r_coll         <= 1'b0;
            r_bit          <= '0;
            r_wc           <= '0;
            r_odd          <= '0;
            r_sum          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_TRACK_WORDS:  r_track_words  <= i_cfg_data[TwW-1:0];
                    CFG_EXPECTED_SUM: r_expected_sum <= i_cfg_data;
                    default: ;
                endcase
            end
            r_win  <= n_win;
            r_coll <= n_coll;
            r_bit  <= n_bit;
            r_wc   <= n_wc;
            r_odd  <= n_odd;
            r_sum  <= n_sum;
        end
    end

    // output register with a one-deep skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_xfer) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_xfer) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_xfer) begin
                r_out_kind <= r_skid_kind;
                r_out_data <= r_skid_data;
                r_out_idx  <= r_skid_idx;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_xfer) begin
                r_out_kind <= res_kind;
                r_out_data <= res_data;
                r_out_idx  <= res_idx;
            end else begin
                r_skid_kind <= res_kind;
                r_skid_data <= res_data;
                r_skid_idx  <= res_idx;
            end
        end
    end

    `ASSERT_RST(a_skid_implies_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid)
    `ASSERT_RST(a_bitcnt_only_collecting, i_clk, i_rst_n, (r_bit != '0) |-> r_coll)
    `ASSERT_RST(a_end_clears, i_clk, i_rst_n,
        (in_xfer && i_bits.stream_end) |=> (!r_coll && r_win == '0 && r_wc == '0))
    `ASSERT_RST(a_skid_held_on_stall, i_clk, i_rst_n,
        (r_skid_valid && !o_words.ready) |=> (r_skid_valid && $stable(r_out_data)))

endmodule

`default_nettype wire
